// File: sv/lfu_pkg.sv
// Package for the LFU cache core: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package lfu_pkg;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
  localparam logic        OP_GET     = 1'b0;
  localparam logic        OP_PUT     = 1'b1;

  // Entry contents as they travel along the cell chain.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] count;
    logic [63:0] stamp;
  } entry_t;

  // Command broadcast by the sequencer to every cell.
  typedef struct packed {
    logic        shift;  // rotate the chain by one
    logic        write;  // head cell takes wr_entry instead of its neighbor
    entry_t      wr_entry;
  } cell_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_ALIGN = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;
endpackage

// File: sv/lfu_cell.sv
// One storage cell of the LFU cache chain; passes its entry to its neighbor.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
module lfu_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lfu_pkg::cell_ctl_t ctl,
  input  logic               is_head,
  input  lfu_pkg::entry_t    from_prev,
  output lfu_pkg::entry_t    entry
);
  lfu_pkg::entry_t entry_r, entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift) begin
      if (is_head && ctl.write) begin
        entry_nxt = ctl.wr_entry;
      end else begin
        entry_nxt = from_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.key   <= entry_nxt.key;
    entry_r.value <= entry_nxt.value;
    entry_r.count <= entry_nxt.count;
    entry_r.stamp <= entry_nxt.stamp;
  end

  assign entry = entry_r;
endmodule

// File: sv/lfu_cache_lru_tiebreak_core.sv
// Top level of the LFU cache with LRU tie-break: sequencer plus a ring of cells.
// Depends on lfu_pkg and lfu_cell.
`timescale 1ns / 1ps
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_operation/key/value | into core
//  out     | out_valid, out_stall, out_found/read_value | out of core
//  cfg     | cfg_we, cfg_capacity                      | into core
//
// Each transaction rotates the ring of ENTRIES cells once to scan keys and pick
// the victim, then rotates again to bring the chosen slot to the head cell and
// write it.
// Reset is synchronous and active low; it clears valid bits, the access clock,
// the held count and the capacity. A get result waits in the output register
// while out_stall is high; no new item is taken until it leaves.
module lfu_cache_lru_tiebreak_core #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_capacity,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [31:0] out_read_value
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  lfu_pkg::state_t state_r, state_nxt;
  lfu_pkg::entry_t ring [ENTRIES];
  lfu_pkg::cell_ctl_t ctl;

  logic [4:0]  cap_r;
  logic [CW-1:0] held_r, held_nxt;
  logic [63:0] clk_r, clk_nxt;
  logic        op_r;
  logic [31:0] key_r, val_r;
  logic [IW:0] step_r, step_nxt;
  // Positions are offsets from the head at scan start.
  logic        hit_r, hit_nxt, free_r, free_nxt, vic_ok_r, vic_ok_nxt;
  logic [IW-1:0] hit_pos_r, hit_pos_nxt, free_pos_r, free_pos_nxt, vic_pos_r, vic_pos_nxt;
  logic [31:0] vic_cnt_r, vic_cnt_nxt;
  logic [63:0] vic_stamp_r, vic_stamp_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic        do_write_r, do_write_nxt;
  logic        out_valid_r, out_valid_nxt, out_found_r, out_found_nxt;
  logic [31:0] out_val_r, out_val_nxt;
  logic [CW-1:0] live_cap;
  lfu_pkg::entry_t head, wr;

  assign live_cap = (int'(cap_r) > ENTRIES) ? CW'(ENTRIES) : CW'(cap_r);
  assign head = ring[ENTRIES-1];

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      lfu_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .is_head(g == 0),
        .from_prev(ring[(g + ENTRIES - 1) % ENTRIES]), .entry(ring[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    held_nxt = held_r;
    clk_nxt = clk_r;
    step_nxt = step_r;
    hit_nxt = hit_r; hit_pos_nxt = hit_pos_r;
    free_nxt = free_r; free_pos_nxt = free_pos_r;
    vic_ok_nxt = vic_ok_r; vic_pos_nxt = vic_pos_r;
    vic_cnt_nxt = vic_cnt_r; vic_stamp_nxt = vic_stamp_r;
    tgt_nxt = tgt_r; do_write_nxt = do_write_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r; out_val_nxt = out_val_r;
    ctl = '0;
    wr = head;
    case (state_r)
      lfu_pkg::ST_IDLE: begin
        if (in_valid && !out_valid_r) begin
          state_nxt = lfu_pkg::ST_SCAN;
          step_nxt = '0;
          hit_nxt = 1'b0; free_nxt = 1'b0; vic_ok_nxt = 1'b0;
        end
      end
      lfu_pkg::ST_SCAN: begin
        // Head cell (last of ring) is inspected, then the ring rotates.
        ctl.shift = 1'b1;
        if (head.valid && head.key == key_r && !hit_r) begin
          hit_nxt = 1'b1; hit_pos_nxt = step_r[IW-1:0];
        end
        if (!head.valid && !free_r) begin
          free_nxt = 1'b1; free_pos_nxt = step_r[IW-1:0];
        end
        if (head.valid && (!vic_ok_r || head.count < vic_cnt_r ||
            (head.count == vic_cnt_r && head.stamp < vic_stamp_r))) begin
          vic_ok_nxt = 1'b1; vic_pos_nxt = step_r[IW-1:0];
          vic_cnt_nxt = head.count; vic_stamp_nxt = head.stamp;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == (IW+1)'(ENTRIES - 1)) begin
          state_nxt = lfu_pkg::ST_ALIGN;
          step_nxt = '0;
          do_write_nxt = 1'b0;
          if (live_cap == '0) begin
            do_write_nxt = 1'b0;
          end else if (hit_nxt) begin
            do_write_nxt = 1'b1; tgt_nxt = hit_pos_nxt;
          end else if (op_r == lfu_pkg::OP_PUT) begin
            if (held_r >= live_cap) begin
              do_write_nxt = vic_ok_nxt; tgt_nxt = vic_pos_nxt;
            end else begin
              do_write_nxt = free_nxt; tgt_nxt = free_pos_nxt;
            end
          end
        end
      end
      lfu_pkg::ST_ALIGN: begin
        // Rotate until the target entry sits at the head cell.
        if (!do_write_r || step_r[IW-1:0] == tgt_r) begin
          state_nxt = lfu_pkg::ST_WRITE;
        end else begin
          ctl.shift = 1'b1;
          step_nxt = step_r + 1'b1;
        end
      end
      lfu_pkg::ST_WRITE: begin
        // Write the head entry back as it shifts, then finish the rotation.
        ctl.shift = 1'b1;
        if (do_write_r) begin
          ctl.write = 1'b1;
          do_write_nxt = 1'b0;
          if (hit_r) begin
            wr.count = (head.count != lfu_pkg::COUNT_MAX) ? head.count + 1'b1 : head.count;
            wr.stamp = clk_r;
            if (op_r == lfu_pkg::OP_PUT) wr.value = val_r;
          end else begin
            wr.valid = 1'b1; wr.key = key_r; wr.value = val_r;
            wr.count = 32'd1; wr.stamp = clk_r;
            if (held_r < live_cap) held_nxt = held_r + 1'b1;
          end
          clk_nxt = clk_r + 64'd1;
          if (op_r == lfu_pkg::OP_GET) out_val_nxt = head.value;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == (IW+1)'(ENTRIES - 1)) begin
          state_nxt = lfu_pkg::ST_OUT;
        end
      end
      lfu_pkg::ST_OUT: begin
        state_nxt = lfu_pkg::ST_IDLE;
        if (op_r == lfu_pkg::OP_GET) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r && live_cap != '0;
          if (!(hit_r && live_cap != '0)) out_val_nxt = lfu_pkg::MISS_VALUE;
        end
      end
      default: state_nxt = lfu_pkg::ST_IDLE;
    endcase
    ctl.wr_entry = wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
      cap_r <= '0; held_r <= '0; clk_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_capacity;
      held_r <= held_nxt; clk_r <= clk_nxt; out_valid_r <= out_valid_nxt;
    end
    if (state_r == lfu_pkg::ST_IDLE && in_valid && !out_valid_r) begin
      op_r <= in_operation; key_r <= in_key; val_r <= in_value;
    end
    step_r <= step_nxt;
    hit_r <= hit_nxt; hit_pos_r <= hit_pos_nxt;
    free_r <= free_nxt; free_pos_r <= free_pos_nxt;
    vic_ok_r <= vic_ok_nxt; vic_pos_r <= vic_pos_nxt;
    vic_cnt_r <= vic_cnt_nxt; vic_stamp_r <= vic_stamp_nxt;
    tgt_r <= tgt_nxt; do_write_r <= do_write_nxt;
    out_found_r <= out_found_nxt; out_val_r <= out_val_nxt;
  end

  assign in_stall = (state_r != lfu_pkg::ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_read_value = out_val_r;
endmodule

// File: sv/lfu_checker.sv
// Port-level checker for the LFU cache core, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module lfu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [31:0] out_read_value
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value))
    else $error("stalled result changed");
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_read_value == 32'hFFFF_FFFF)
    else $error("miss without -1");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken at once");
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("accepted while result pending");
endmodule

bind lfu_cache_lru_tiebreak_core lfu_checker u_lfu_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
  .out_read_value(out_read_value)
);
